@@ sv/line_regex_subset_matcher_assert.svh @@
// Assertion macros for the line pattern matcher.
`ifndef LINE_REGEX_SUBSET_MATCHER_ASSERT_SVH
`define LINE_REGEX_SUBSET_MATCHER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define LRSM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lrsm same-cycle check failed");
`define LRSM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lrsm next-cycle check failed");
`else
`define LRSM_ASSERT_SAME(label, ante, cons)
`define LRSM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/lrsm_pkg.sv @@
// Shared types and constants of the line pattern matcher.
`timescale 1ns / 1ps

package lrsm_pkg;

    localparam int LRSM_MAX_ATOMS = 16;
    localparam int CFG_ADDR_W     = 6;
    localparam int CFG_DATA_W     = 64;

    typedef enum logic [2:0] {
        REG_ATOM_COUNT = 3'd0,
        REG_ANCHORED   = 3'd1,
        REG_QUANT_POS  = 3'd2,
        REG_QUANT_KIND = 3'd3,
        REG_CHARS_LOW  = 3'd4,
        REG_CHARS_HIGH = 3'd5,
        REG_WILDCARD   = 3'd6
    } t_reg_idx;

    localparam logic [1:0] QK_NONE      = 2'd0;
    localparam logic [1:0] QK_OPTIONAL  = 2'd1;
    localparam logic [1:0] QK_ONE_MORE  = 2'd2;
    localparam logic [1:0] QK_ZERO_MORE = 2'd3;

    typedef struct packed {
        logic       step;
        logic       clear;
        logic       has_byte;
        logic [7:0] text_byte;
    } t_step_ctl;

endpackage

@@ sv/lrsm_cell.sv @@
// One NFA position cell: holds the activity bit after its atom.
`timescale 1ns / 1ps

module lrsm_cell
    import lrsm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_step_ctl i_ctl,
    input  logic [7:0] i_atom,
    input  logic      i_wild,
    input  logic      i_en,
    input  logic      i_opt,
    input  logic      i_rep,
    input  logic      i_cur,
    input  logic      i_probe,
    output logic      o_cur,
    output logic      o_after,
    output logic      o_probe
);

    logic r_active;
    logic n_active;
    logic hit;

    assign hit     = i_wild | (i_atom == i_ctl.text_byte);
    assign o_cur   = (r_active & i_en) | (i_opt & i_cur);
    assign o_after = i_en & hit & (i_cur | (i_rep & o_cur));
    assign o_probe = o_after | (i_opt & i_probe);

    always_comb begin
        n_active = r_active;
        if (i_ctl.step) begin
            if (i_ctl.clear) begin
                n_active = 1'b0;
            end else if (i_ctl.has_byte) begin
                n_active = o_after;
            end else begin
                n_active = o_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

endmodule

@@ sv/line_regex_subset_matcher.sv @@
// A line-end transfer gives its result on the output register in the cycle after it.
// Throughput: one item per cycle when the input is not stalled; the cell row updates every NFA position in parallel.
// Input stalls only while a finished result waits in the output register to be taken.
// Reset (synchronous, active low) clears all registers and the position row to the
// start position; no clearing pass is needed.
`timescale 1ns / 1ps

module line_regex_subset_matcher
    import lrsm_pkg::*;
#(
    parameter int MAX_ATOMS = LRSM_MAX_ATOMS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_text_byte,
    input  logic                  i_has_byte,
    input  logic                  i_line_end,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_line_matches
);

    localparam int IW = $clog2(MAX_ATOMS + 1);

    logic [4:0]   r_atom_count;
    logic         r_anchored;
    logic [3:0]   r_qpos;
    logic [1:0]   r_qkind;
    logic [63:0]  r_chars_low;
    logic [63:0]  r_chars_high;
    logic [15:0]  r_wild;

    logic         r_act0;
    logic         n_act0;
    logic         r_line_start;
    logic         n_line_start;
    logic         r_seen;
    logic         n_seen;
    logic         r_out_valid;
    logic         n_out_valid;
    logic         r_match;
    logic         n_match;

    logic         cfg_wr;
    t_reg_idx     reg_idx;
    logic         in_xfer;
    logic [IW-1:0] used;
    logic         quant_on;
    logic         q_opt;
    logic         q_rep;
    logic [127:0] chars_all;
    logic         cur0;
    logic         line_hit;
    t_step_ctl    ctl;

    logic [MAX_ATOMS:0]   cur_vec;
    logic [MAX_ATOMS:0]   probe_vec;
    logic [MAX_ATOMS-1:0] after_vec;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign reg_idx = t_reg_idx'(paddr[5:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atom_count <= '0;
            r_anchored   <= 1'b0;
            r_qpos       <= '0;
            r_qkind      <= QK_NONE;
            r_chars_low  <= '0;
            r_chars_high <= '0;
            r_wild       <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ATOM_COUNT: r_atom_count <= pwdata[4:0];
                REG_ANCHORED:   r_anchored   <= pwdata[0];
                REG_QUANT_POS:  r_qpos       <= pwdata[3:0];
                REG_QUANT_KIND: r_qkind      <= pwdata[1:0];
                REG_CHARS_LOW:  r_chars_low  <= pwdata;
                REG_CHARS_HIGH: r_chars_high <= pwdata;
                REG_WILDCARD:   r_wild       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ATOM_COUNT: prdata = {59'd0, r_atom_count};
            REG_ANCHORED:   prdata = {63'd0, r_anchored};
            REG_QUANT_POS:  prdata = {60'd0, r_qpos};
            REG_QUANT_KIND: prdata = {62'd0, r_qkind};
            REG_CHARS_LOW:  prdata = r_chars_low;
            REG_CHARS_HIGH: prdata = r_chars_high;
            REG_WILDCARD:   prdata = {48'd0, r_wild};
            default:        prdata = '0;
        endcase
    end

    assign used      = (r_atom_count > 5'(MAX_ATOMS)) ? IW'(MAX_ATOMS) : r_atom_count[IW-1:0];
    assign quant_on  = (r_qkind != QK_NONE) && (5'(r_qpos) < 5'(used));
    assign q_opt     = quant_on && (r_qkind == QK_OPTIONAL || r_qkind == QK_ZERO_MORE);
    assign q_rep     = quant_on && (r_qkind == QK_ONE_MORE || r_qkind == QK_ZERO_MORE);
    assign chars_all = {r_chars_high, r_chars_low};

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    assign ctl.step      = in_xfer;
    assign ctl.clear     = i_line_end;
    assign ctl.has_byte  = i_has_byte;
    assign ctl.text_byte = i_text_byte;

    assign cur0         = r_act0 | !r_anchored | r_line_start;
    assign cur_vec[0]   = cur0;
    assign probe_vec[0] = !r_anchored;

    for (genvar gi = 0; gi < MAX_ATOMS; gi++) begin : g_cell
        lrsm_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_atom  (chars_all[8*gi +: 8]),
            .i_wild  (r_wild[gi]),
            .i_en    (IW'(gi) < used),
            .i_opt   (q_opt && (r_qpos == 4'(gi))),
            .i_rep   (q_rep && (r_qpos == 4'(gi))),
            .i_cur   (cur_vec[gi]),
            .i_probe (probe_vec[gi]),
            .o_cur   (cur_vec[gi+1]),
            .o_after (after_vec[gi]),
            .o_probe (probe_vec[gi+1])
        );
    end

    assign line_hit = r_seen | cur_vec[used] | (i_has_byte & probe_vec[used]);

    always_comb begin
        n_act0       = r_act0;
        n_line_start = r_line_start;
        n_seen       = r_seen;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_match      = r_match;
        if (in_xfer) begin
            if (i_line_end) begin
                n_act0       = 1'b1;
                n_line_start = 1'b1;
                n_seen       = 1'b0;
                n_out_valid  = 1'b1;
                n_match      = line_hit;
            end else begin
                n_act0       = i_has_byte ? 1'b0 : cur0;
                n_line_start = r_line_start & !i_has_byte;
                n_seen       = line_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act0       <= 1'b1;
            r_line_start <= 1'b1;
            r_seen       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_match      <= 1'b0;
        end else begin
            r_act0       <= n_act0;
            r_line_start <= n_line_start;
            r_seen       <= n_seen;
            r_out_valid  <= n_out_valid;
            r_match      <= n_match;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_matches = r_match;

`include "line_regex_subset_matcher_assert.svh"

    `LRSM_ASSERT_NEXT(a_end_gives_result, in_xfer && i_line_end, o_out_valid)
    `LRSM_ASSERT_NEXT(a_end_restarts, in_xfer && i_line_end, r_act0 && r_line_start && !r_seen)
    `LRSM_ASSERT_NEXT(a_byte_leaves_start, in_xfer && i_has_byte && !i_line_end, !r_line_start)
    `LRSM_ASSERT_SAME(a_no_after_past_end, 1'b1, (after_vec >> used) == '0)

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the line pattern matcher: streams lines, predicts each verdict.
`timescale 1ns / 1ps

module testbench;
    import lrsm_pkg::*;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_byte;
        logic       line_end;
    } t_line_item;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            text_byte = '0;
    logic                  has_byte = 1'b0;
    logic                  line_end = 1'b0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    logic                  o_line_matches;

    // pattern registers as the block should hold them
    logic [4:0]  cfg_count = '0;
    logic        cfg_anchored = 1'b0;
    logic [3:0]  cfg_qpos = '0;
    logic [1:0]  cfg_qkind = QK_NONE;
    logic [63:0] cfg_lo = '0;
    logic [63:0] cfg_hi = '0;
    logic [15:0] cfg_wild = '0;

    // NFA state of the line in progress
    logic [16:0] nfa_active = 17'd1;
    logic        seen_match = 1'b0;
    logic        at_line_start = 1'b1;

    t_line_item  feed_q[$];
    t_line_item  cur_item;
    logic        verdicts_due[$];
    logic [7:0]  line_buf[$];
    int          items_queued = 0;
    int          mismatches = 0;

    line_regex_subset_matcher i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (text_byte),
        .i_has_byte     (has_byte),
        .i_line_end     (line_end),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_line_matches (o_line_matches)
    );

    always #5 i_clk = ~i_clk;

    function automatic int eff_atoms();
        return (cfg_count > 5'd16) ? 16 : int'(cfg_count);
    endfunction

    function automatic logic atom_hits(int i, logic [7:0] b);
        logic [127:0] chars;
        chars = {cfg_hi, cfg_lo};
        return cfg_wild[i] || (chars[i*8 +: 8] == b);
    endfunction

    function automatic logic quant_live(int n);
        return (cfg_qkind != QK_NONE) && (int'(cfg_qpos) < n);
    endfunction

    function automatic logic [16:0] eps_close(logic [16:0] set, int n);
        int qp;
        qp = cfg_qpos;
        if (quant_live(n) && (cfg_qkind == QK_OPTIONAL || cfg_qkind == QK_ZERO_MORE)
                && set[qp])
            set[qp + 1] = 1'b1;
        return set;
    endfunction

    function automatic logic [16:0] advance(logic [16:0] set, int n, logic [7:0] b);
        logic [16:0] nxt;
        int          qp;
        nxt = '0;
        qp = cfg_qpos;
        for (int i = 0; i < n; i++)
            if (set[i] && atom_hits(i, b))
                nxt[i + 1] = 1'b1;
        if (quant_live(n) && (cfg_qkind == QK_ONE_MORE || cfg_qkind == QK_ZERO_MORE)
                && set[qp + 1] && atom_hits(qp, b))
            nxt[qp + 1] = 1'b1;
        return nxt;
    endfunction

    function automatic void track_line(t_line_item it);
        int          n;
        logic [16:0] span, inject, cur, after, probe, nxt;
        n = eff_atoms();
        span = 17'((32'd1 << (n + 1)) - 1);
        inject = (!cfg_anchored || at_line_start) ? 17'd1 : 17'd0;
        cur = eps_close((nfa_active | inject) & span, n);
        nxt = cur;
        if (cur[n])
            seen_match = 1'b1;
        if (it.has_byte) begin
            after = advance(cur, n, it.text_byte);
            probe = eps_close(after | (cfg_anchored ? 17'd0 : 17'd1), n);
            if (probe[n])
                seen_match = 1'b1;
            nxt = after & span;
            at_line_start = 1'b0;
        end
        if (it.line_end) begin
            verdicts_due.push_back(seen_match);
            nfa_active = 17'd1;
            seen_match = 1'b0;
            at_line_start = 1'b1;
        end else begin
            nfa_active = nxt;
        end
    endfunction

    function automatic logic pause_roll();
        return ((($time / 10) % 2500) >= 600) && ($urandom_range(0, 99) < 16);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready)
                track_line(cur_item);
            if (!in_valid || o_in_ready) begin
                if (feed_q.size() != 0 && !pause_roll()) begin
                    cur_item = feed_q.pop_front();
                    in_valid <= 1'b1;
                    text_byte <= cur_item.text_byte;
                    has_byte <= cur_item.has_byte;
                    line_end <= cur_item.line_end;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: unexpected verdict %b", $time, o_line_matches);
                    mismatches++;
                end else if (o_line_matches !== verdicts_due[0]) begin
                    $display("%0t: line_matches expected %b actual %b", $time,
                             verdicts_due[0], o_line_matches);
                    mismatches++;
                    void'(verdicts_due.pop_front());
                end else begin
                    void'(verdicts_due.pop_front());
                end
            end
            out_ready <= !pause_roll();
        end
    end

    task automatic settle();
        @(negedge i_clk);
        while (feed_q.size() != 0 || in_valid || verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ATOM_COUNT: cfg_count = val[4:0];
            REG_ANCHORED:   cfg_anchored = val[0];
            REG_QUANT_POS:  cfg_qpos = val[3:0];
            REG_QUANT_KIND: cfg_qkind = val[1:0];
            REG_CHARS_LOW:  cfg_lo = val;
            REG_CHARS_HIGH: cfg_hi = val;
            REG_WILDCARD:   cfg_wild = val[15:0];
            default: ;
        endcase
    endtask

    function automatic void queue_item(logic [7:0] b, logic has, logic last);
        t_line_item it;
        it.text_byte = b;
        it.has_byte = has;
        it.line_end = last;
        feed_q.push_back(it);
        items_queued++;
    endfunction

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 99) < 85)
            return 8'(8'h61 + $urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void add_instance(logic truncate);
        int           reps;
        logic [127:0] chars;
        chars = {cfg_hi, cfg_lo};
        for (int i = 0; i < eff_atoms(); i++) begin
            reps = 1;
            if (cfg_qkind != QK_NONE && int'(cfg_qpos) == i) begin
                case (cfg_qkind)
                    QK_OPTIONAL: reps = $urandom_range(0, 1);
                    QK_ONE_MORE: reps = $urandom_range(1, 3);
                    default:     reps = $urandom_range(0, 3);
                endcase
            end
            repeat (reps) line_buf.push_back(cfg_wild[i] ? pick_byte() : chars[i*8 +: 8]);
        end
        if (truncate && line_buf.size() != 0)
            void'(line_buf.pop_back());
    endfunction

    function automatic void close_line();
        logic tail;
        int   last;
        tail = (line_buf.size() == 0) || ($urandom_range(0, 19) == 0);
        last = line_buf.size() - 1;
        for (int k = 0; k <= last; k++) begin
            if ($urandom_range(0, 99) < 4)
                queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            queue_item(line_buf[k], 1'b1, (k == last) && !tail);
        end
        if (tail)
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        line_buf.delete();
    endfunction

    function automatic void build_line();
        int r;
        int pre;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            return;
        end
        pre = (cfg_anchored && $urandom_range(0, 1)) ? 0 : $urandom_range(0, 4);
        repeat (pre) line_buf.push_back(pick_byte());
        if (r < 75)
            add_instance(r >= 65);
        repeat ($urandom_range(0, 3)) line_buf.push_back(pick_byte());
        close_line();
    endfunction

    task automatic random_phase(int goal);
        int          r, cnt, k, stop;
        logic [63:0] lo, hi;
        logic [15:0] wm;
        settle();
        r = $urandom_range(0, 99);
        if (r < 8)
            cnt = 0;
        else if (r < 16)
            cnt = 16;
        else if (r < 22)
            cnt = $urandom_range(17, 31);
        else
            cnt = $urandom_range(1, 6);
        reg_write(REG_ATOM_COUNT, cnt);
        reg_write(REG_ANCHORED, $urandom_range(0, 1));
        k = eff_atoms();
        reg_write(REG_QUANT_POS, (k > 0 && $urandom_range(0, 99) < 80) ?
                  $urandom_range(0, k - 1) : $urandom_range(0, 15));
        reg_write(REG_QUANT_KIND, $urandom_range(0, 3));
        for (int i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = pick_byte();
            hi[i*8 +: 8] = pick_byte();
        end
        for (int i = 0; i < 16; i++)
            wm[i] = ($urandom_range(0, 99) < 12);
        reg_write(REG_CHARS_LOW, lo);
        reg_write(REG_CHARS_HIGH, hi);
        reg_write(REG_WILDCARD, wm);
        stop = items_queued + goal;
        while (items_queued < stop)
            build_line();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // empty pattern matches even an empty line
        queue_item(8'h00, 1'b0, 1'b1);
        settle();

        // a followed by a*, needs the NFA rather than a greedy scan
        reg_write(REG_ATOM_COUNT, 2);
        reg_write(REG_CHARS_LOW, 64'h6161);
        reg_write(REG_QUANT_POS, 1);
        reg_write(REG_QUANT_KIND, QK_ZERO_MORE);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h61, 1'b1, 1'b1);
        queue_item(8'h0A, 1'b1, 1'b0);
        queue_item(8'h61, 1'b1, 1'b1);
        settle();

        // oversize atom count clamps to sixteen wildcards, anchored
        reg_write(REG_ATOM_COUNT, 31);
        reg_write(REG_ANCHORED, 1);
        reg_write(REG_WILDCARD, 16'hFFFF);
        reg_write(REG_CHARS_LOW, '1);
        reg_write(REG_CHARS_HIGH, '1);
        reg_write(REG_QUANT_KIND, QK_NONE);
        queue_item(8'hFF, 1'b1, 1'b0);
        queue_item(8'h00, 1'b0, 1'b0);
        queue_item(8'h00, 1'b1, 1'b1);
        settle();

        // quantifier past the last atom is ignored
        reg_write(REG_ATOM_COUNT, 2);
        reg_write(REG_ANCHORED, 0);
        reg_write(REG_WILDCARD, 0);
        reg_write(REG_CHARS_LOW, 64'h6261);
        reg_write(REG_QUANT_POS, 15);
        reg_write(REG_QUANT_KIND, QK_OPTIONAL);
        queue_item(8'h62, 1'b1, 1'b1);

        // shrink the pattern in the middle of a line
        queue_item(8'h61, 1'b1, 1'b0);
        settle();
        reg_write(REG_ATOM_COUNT, 1);
        queue_item(8'h71, 1'b1, 1'b1);
        settle();

        reg_write(REG_ATOM_COUNT, 3);
        reg_write(REG_CHARS_LOW, 64'h636261);
        reg_write(REG_QUANT_POS, 1);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        settle();
        reg_write(REG_QUANT_KIND, QK_ONE_MORE);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);
        settle();
        reg_write(REG_ANCHORED, 1);
        queue_item(8'h78, 1'b1, 1'b0);
        queue_item(8'h61, 1'b1, 1'b0);
        queue_item(8'h62, 1'b1, 1'b0);
        queue_item(8'h63, 1'b1, 1'b1);

        for (int p = 0; p < 20; p++)
            random_phase(85);

        settle();
        repeat (6) @(posedge i_clk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("line_regex_subset_matcher verification clean");
        else
            $display("line_regex_subset_matcher verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("line_regex_subset_matcher verification failed");
        $finish;
    end

endmodule
